@@ sv/indexed_doubly_linked_list_core_defines.svh @@
// Assertion macros for the list core.
// Define ASSERT_OFF to compile the checks away.
`ifndef INDEXED_DOUBLY_LINKED_LIST_CORE_DEFINES_SVH
`define INDEXED_DOUBLY_LINKED_LIST_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high.
`define IDLL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list core check failed");

// Next-cycle implication, disabled while reset is high.
`define IDLL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list core check failed");

`else

`define IDLL_ASSERT_IMP(label, clk, rst, ante, cons)
`define IDLL_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/idll_pkg.sv @@
`timescale 1ns / 1ps

package idll_pkg;

   // Field widths of the request and response words.
   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 32;

   // Request actions. Codes 5 to 7 change no memory but still get a response word.
   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD       = 3'd0,
      ACT_INS_AFTER  = 3'd1,
      ACT_INS_BEFORE = 3'd2,
      ACT_DELETE     = 3'd3,
      ACT_READ       = 3'd4
   } action_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_LINK,
      ST_HOLD
   } state_type;

endpackage

@@ sv/idll_req_if.sv @@
`timescale 1ns / 1ps

interface idll_req_if;
   import idll_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [INDEX_W-1:0]         node_index;
   logic signed [VALUE_W-1:0]  value;
   logic [INDEX_W-1:0]         link_next;
   logic [INDEX_W-1:0]         link_prev;

   modport source (
      output valid, action, node_index, value, link_next, link_prev,
      input  ready
   );

   modport sink (
      input  valid, action, node_index, value, link_next, link_prev,
      output ready
   );

endinterface

@@ sv/idll_rsp_if.sv @@
`timescale 1ns / 1ps

interface idll_rsp_if;
   import idll_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  result_value;
   logic [INDEX_W-1:0]         result_index;
   logic [INDEX_W-1:0]         result_next;
   logic [INDEX_W-1:0]         result_prev;
   logic                       pool_full;

   modport source (
      output valid, result_value, result_index, result_next, result_prev, pool_full,
      input  ready
   );

   modport sink (
      input  valid, result_value, result_index, result_next, result_prev, pool_full,
      output ready
   );

endinterface

@@ sv/idll_ram.sv @@
`timescale 1ns / 1ps

module idll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // One read port with registered data; the data holds while re is low.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/indexed_doubly_linked_list_core.sv @@
`timescale 1ns / 1ps
// Requests are taken only when idle. The sequencer reads the named node entry, makes
// any writes in the execute state and, for an insert, in the link state, on the single
// write port of each link memory, and goes idle once its word is in the response slot.
// Reset is synchronous: the free pointer returns to 1 and the response slot empties;
// the node memories are not cleared and hold whatever was last written.
`include "indexed_doubly_linked_list_core_defines.svh"

module indexed_doubly_linked_list_core #(
   parameter int NODE_COUNT = 1024
) (
   input  logic      clock,
   input  logic      reset,
   idll_req_if.sink   req_chan,
   idll_rsp_if.source rsp_chan
);
   import idll_pkg::*;

   localparam int IDX_W      = $clog2(NODE_COUNT);
   localparam int FP_W       = $clog2(NODE_COUNT + 1);
   // Compare-subtract steps that reduce any request index below NODE_COUNT (NODE_COUNT >= 4).
   localparam int FOLD_STEPS = INDEX_W - 2;

   // Reduces a request index modulo NODE_COUNT by scaled compare and subtract.
   function automatic logic [IDX_W-1:0] fold(input logic [INDEX_W-1:0] x);
      int r;
      r = int'(x);
      for (int k = FOLD_STEPS - 1; k >= 0; k--) begin
         if (r >= (NODE_COUNT << k)) begin
            r = r - (NODE_COUNT << k);
         end
      end
      return IDX_W'(r);
   endfunction

   state_type                 state_ff, state_in;
   action_type                act_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [INDEX_W-1:0]        raw_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [IDX_W-1:0]          lnx_ff;
   logic [IDX_W-1:0]          lpv_ff;
   logic [FP_W-1:0]           fp_ff, fp_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic [INDEX_W-1:0]        rsp_next_ff;
   logic [INDEX_W-1:0]        rsp_prev_ff;
   logic                      rsp_full_ff;

   logic                      req_accept;
   logic                      is_insert;
   logic                      pool_empty;
   logic                      insert_ok;
   logic                      res_ready;
   logic                      res_take;
   logic                      slot_free;
   logic [IDX_W-1:0]          free_node;
   logic [FP_W-1:0]           idx_plus_one;

   logic                      mem_re;
   logic                      val_we, next_we, prev_we;
   logic [IDX_W-1:0]          val_wa, next_wa, prev_wa;
   logic [VALUE_W-1:0]        val_wd;
   logic [IDX_W-1:0]          next_wd, prev_wd;
   logic [VALUE_W-1:0]        val_rd;
   logic [IDX_W-1:0]          next_rd, prev_rd;

   logic signed [VALUE_W-1:0] res_value;
   logic [INDEX_W-1:0]        res_index;
   logic [INDEX_W-1:0]        res_next;
   logic [INDEX_W-1:0]        res_prev;

   // Node memories: values, next links and previous links.
   idll_ram #(.WIDTH(VALUE_W), .DEPTH(NODE_COUNT)) u_val_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (val_wa),
      .wdata (val_wd),
      .re    (mem_re),
      .raddr (idx_ff),
      .rdata (val_rd)
   );

   idll_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_next_ram (
      .clock (clock),
      .we    (next_we),
      .waddr (next_wa),
      .wdata (next_wd),
      .re    (mem_re),
      .raddr (idx_ff),
      .rdata (next_rd)
   );

   idll_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_prev_ram (
      .clock (clock),
      .we    (prev_we),
      .waddr (prev_wa),
      .wdata (prev_wd),
      .re    (mem_re),
      .raddr (idx_ff),
      .rdata (prev_rd)
   );

   // Common decode of the request held in the sequencer.
   assign req_accept   = req_chan.valid && req_chan.ready;
   assign is_insert    = (act_ff == ACT_INS_AFTER) || (act_ff == ACT_INS_BEFORE);
   assign pool_empty   = fp_ff >= FP_W'(NODE_COUNT);
   assign insert_ok    = is_insert && !pool_empty;
   assign free_node    = fp_ff[IDX_W-1:0];
   assign idx_plus_one = FP_W'(idx_ff) + FP_W'(1);
   assign slot_free    = !rsp_valid_ff || rsp_chan.ready;

   // A finished word is ready to move into the response slot.
   always_comb begin
      case (state_ff)
         ST_EXEC: res_ready = !insert_ok;
         ST_LINK: res_ready = 1'b1;
         ST_HOLD: res_ready = 1'b1;
         default: res_ready = 1'b0;
      endcase
   end

   assign res_take = res_ready && slot_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (insert_ok) begin
               state_in = ST_LINK;
            end else if (slot_free) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_LINK, ST_HOLD: begin
            state_in = slot_free ? ST_IDLE : ST_HOLD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory controls: read the named node, then load, splice or unlink in one or two writes.
   always_comb begin
      req_chan.ready = 1'b0;
      mem_re  = 1'b0;
      val_we  = 1'b0;
      val_wa  = idx_ff;
      val_wd  = VALUE_W'(val_ff);
      next_we = 1'b0;
      next_wa = idx_ff;
      next_wd = lnx_ff;
      prev_we = 1'b0;
      prev_wa = idx_ff;
      prev_wd = lpv_ff;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_READ: begin
            mem_re = 1'b1;
         end
         ST_EXEC: begin
            case (act_ff)
               ACT_LOAD: begin
                  val_we  = 1'b1;
                  next_we = 1'b1;
                  prev_we = 1'b1;
               end
               ACT_INS_AFTER: begin
                  // New node takes the old successor and points back at the named node.
                  val_we  = !pool_empty;
                  val_wa  = free_node;
                  next_we = !pool_empty;
                  next_wa = free_node;
                  next_wd = next_rd;
                  prev_we = !pool_empty;
                  prev_wa = free_node;
                  prev_wd = idx_ff;
               end
               ACT_INS_BEFORE: begin
                  // New node points at the named node and takes its old predecessor.
                  val_we  = !pool_empty;
                  val_wa  = free_node;
                  next_we = !pool_empty;
                  next_wa = free_node;
                  next_wd = idx_ff;
                  prev_we = !pool_empty;
                  prev_wa = free_node;
                  prev_wd = prev_rd;
               end
               ACT_DELETE: begin
                  // Neighbors skip over the node; its own links stay as they are.
                  next_we = 1'b1;
                  next_wa = prev_rd;
                  next_wd = next_rd;
                  prev_we = 1'b1;
                  prev_wa = next_rd;
                  prev_wd = prev_rd;
               end
               default: begin
               end
            endcase
         end
         ST_LINK: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            if (act_ff == ACT_INS_AFTER) begin
               next_wa = idx_ff;
               next_wd = free_node;
               prev_wa = next_rd;
               prev_wd = free_node;
            end else begin
               next_wa = prev_rd;
               next_wd = free_node;
               prev_wa = idx_ff;
               prev_wd = free_node;
            end
         end
         default: begin
         end
      endcase
   end

   // Response word from the held request and the node read.
   always_comb begin
      res_value = '0;
      res_index = insert_ok ? INDEX_W'(fp_ff) : raw_ff;
      res_next  = '0;
      res_prev  = '0;
      case (act_ff)
         ACT_DELETE: begin
            res_value = val_rd;
         end
         ACT_READ: begin
            res_value = val_rd;
            res_next  = INDEX_W'(next_rd);
            res_prev  = INDEX_W'(prev_rd);
         end
         default: begin
         end
      endcase
   end

   // Free pointer moves when the word of a load or a successful insert is taken.
   always_comb begin
      fp_in = fp_ff;
      if (res_take) begin
         if ((act_ff == ACT_LOAD) && (fp_ff < idx_plus_one)) begin
            fp_in = idx_plus_one;
         end else if (insert_ok) begin
            fp_in = fp_ff + FP_W'(1);
         end
      end
   end

   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_chan.ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fp_ff        <= FP_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fp_ff        <= fp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture, with indices and links reduced to the node range.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff <= action_type'(req_chan.action);
         raw_ff <= req_chan.node_index;
         idx_ff <= fold(req_chan.node_index);
         val_ff <= req_chan.value;
         lnx_ff <= fold(req_chan.link_next);
         lpv_ff <= fold(req_chan.link_prev);
      end
   end

   // Response slot.
   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_value_ff <= res_value;
         rsp_index_ff <= res_index;
         rsp_next_ff  <= res_next;
         rsp_prev_ff  <= res_prev;
         rsp_full_ff  <= is_insert && pool_empty;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.result_index = rsp_index_ff;
   assign rsp_chan.result_next  = rsp_next_ff;
   assign rsp_chan.result_prev  = rsp_prev_ff;
   assign rsp_chan.pool_full    = rsp_full_ff;

   // The free pointer never points at the sentinel and never runs past the pool.
   `IDLL_ASSERT_IMP(a_fp_range, clock, reset, 1'b1, (fp_ff != '0) && (fp_ff <= FP_W'(NODE_COUNT)))
   // The second splice step only runs with a node in hand.
   `IDLL_ASSERT_IMP(a_link_has_node, clock, reset, state_ff == ST_LINK, fp_ff < FP_W'(NODE_COUNT))
   // Memory writes happen only after the node read has returned.
   `IDLL_ASSERT_IMP(a_write_phase, clock, reset, val_we || next_we || prev_we, (state_ff == ST_EXEC) || (state_ff == ST_LINK))
   // A held word waits only behind an occupied response slot.
   `IDLL_ASSERT_IMP(a_hold_blocked, clock, reset, state_ff == ST_HOLD, rsp_valid_ff)
   // A taken word shows up on the response channel in the next cycle.
   `IDLL_ASSERT_NXT(a_take_valid, clock, reset, res_take, rsp_valid_ff)

endmodule

@@ bench/tb_indexed_doubly_linked_list_core.sv @@
`timescale 1ns / 1ps

module tb_indexed_doubly_linked_list_core;
   import idll_pkg::*;

   localparam int NODE_COUNT   = 1 << INDEX_W;
   localparam int RANDOM_OPS   = 1730;
   localparam int PAUSE_AT     = 600;
   localparam int HOLD_AT      = 900;
   localparam int HOLD_CYCLES  = 200;
   localparam int WIDE_LOAD_AT = 1300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;

   // Codes beyond the last defined action leave the memories untouched; the block still answers them.
   localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = ACTION_W'(ACT_READ + 1);
   localparam logic [ACTION_W-1:0] ACT_CODE_MAX     = '1;

   typedef struct {
      logic [ACTION_W-1:0]       action;
      logic [INDEX_W-1:0]        node_index;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        link_next;
      logic [INDEX_W-1:0]        link_prev;
   } list_op_type;

   typedef struct {
      logic signed [VALUE_W-1:0] result_value;
      logic [INDEX_W-1:0]        result_index;
      logic [INDEX_W-1:0]        result_next;
      logic [INDEX_W-1:0]        result_prev;
      logic                      pool_full;
   } list_result_type;

   // Mirror of the node memories and the bump allocator. It predicts the
   // response word for each accepted request and checks returned words in order.
   class list_mirror;
      logic signed [VALUE_W-1:0] node_value [NODE_COUNT];
      logic [INDEX_W-1:0]        next_link  [NODE_COUNT];
      logic [INDEX_W-1:0]        prev_link  [NODE_COUNT];
      bit                        value_known[NODE_COUNT];
      bit                        next_known [NODE_COUNT];
      bit                        prev_known [NODE_COUNT];
      int                        free_slot;
      list_result_type           pending_results[$];
      int                        error_count;

      function new();
         free_slot   = 1;
         error_count = 0;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      // True when the request reads only memory entries that hold written data.
      function bit reads_known(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] at);
         case (act)
            ACT_INS_AFTER:  return free_slot >= NODE_COUNT || next_known[at];
            ACT_INS_BEFORE: return free_slot >= NODE_COUNT || prev_known[at];
            ACT_DELETE,
            ACT_READ:       return value_known[at] && next_known[at] && prev_known[at];
            default:        return 1'b1;
         endcase
      endfunction

      function void note_request(list_op_type op);
         list_result_type    r;
         logic [INDEX_W-1:0] at;
         logic [INDEX_W-1:0] slot;
         r              = '{default: '0};
         r.result_index = op.node_index;
         at             = op.node_index;
         case (op.action)
            ACT_LOAD: begin
               node_value[at]  = op.value;
               next_link[at]   = op.link_next;
               prev_link[at]   = op.link_prev;
               value_known[at] = 1'b1;
               next_known[at]  = 1'b1;
               prev_known[at]  = 1'b1;
               // The allocator only moves up: a load below it leaves it where it is.
               if (free_slot < int'(at) + 1) free_slot = int'(at) + 1;
            end
            ACT_INS_AFTER,
            ACT_INS_BEFORE: begin
               if (free_slot >= NODE_COUNT) begin
                  r.pool_full = 1'b1;
               end else begin
                  slot = INDEX_W'(free_slot);
                  // Each splice step sees the memories as the step before left them.
                  if (op.action == ACT_INS_AFTER) begin
                     next_link[slot] = next_link[at];
                     next_known[slot] = 1'b1;
                     prev_link[slot] = at;
                     prev_known[slot] = 1'b1;
                     prev_link[next_link[at]] = slot;
                     prev_known[next_link[at]] = 1'b1;
                     next_link[at] = slot;
                     next_known[at] = 1'b1;
                  end else begin
                     next_link[slot] = at;
                     next_known[slot] = 1'b1;
                     prev_link[slot] = prev_link[at];
                     prev_known[slot] = 1'b1;
                     next_link[prev_link[at]] = slot;
                     next_known[prev_link[at]] = 1'b1;
                     prev_link[at] = slot;
                     prev_known[at] = 1'b1;
                  end
                  node_value[slot]  = op.value;
                  value_known[slot] = 1'b1;
                  r.result_index    = slot;
                  free_slot         = free_slot + 1;
               end
            end
            ACT_DELETE: begin
               r.result_value = node_value[at];
               next_link[prev_link[at]] = next_link[at];
               next_known[prev_link[at]] = 1'b1;
               prev_link[next_link[at]] = prev_link[at];
               prev_known[next_link[at]] = 1'b1;
            end
            ACT_READ: begin
               r.result_value = node_value[at];
               r.result_next  = next_link[at];
               r.result_prev  = prev_link[at];
            end
            default: begin
            end
         endcase
         pending_results.push_back(r);
      endfunction

      function void check_result(list_result_type got);
         list_result_type want;
         if (pending_results.size() == 0) begin
            $error("response word arrived with no request outstanding");
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
            error_count++;
         end
         if (got.result_index !== want.result_index) begin
            $error("result_index: expected %0d, got %0d", want.result_index, got.result_index);
            error_count++;
         end
         if (got.result_next !== want.result_next) begin
            $error("result_next: expected %0d, got %0d", want.result_next, got.result_next);
            error_count++;
         end
         if (got.result_prev !== want.result_prev) begin
            $error("result_prev: expected %0d, got %0d", want.result_prev, got.result_prev);
            error_count++;
         end
         if (got.pool_full !== want.pool_full) begin
            $error("pool_full: expected %0d, got %0d", want.pool_full, got.pool_full);
            error_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_on;
   int   rsp_hold_cycles;
   int   quiet_cycles;

   list_mirror         board;
   logic [INDEX_W-1:0] linked_nodes[$];

   idll_req_if req_bus ();
   idll_rsp_if rsp_bus ();

   indexed_doubly_linked_list_core #(
      .NODE_COUNT(NODE_COUNT)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // Free-running clock, 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // End the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset === 1'b1 || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic list_op_type op_of(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] at,
                                         logic signed [VALUE_W-1:0] val,
                                         logic [INDEX_W-1:0] nx, logic [INDEX_W-1:0] pv);
      list_op_type op;
      op.action     = act;
      op.node_index = at;
      op.value      = val;
      op.link_next  = nx;
      op.link_prev  = pv;
      return op;
   endfunction

   // Random node whose entries this action may read; the sentinel as a fallback.
   function automatic logic [INDEX_W-1:0] pick_target(logic [ACTION_W-1:0] act);
      logic [INDEX_W-1:0] at;
      repeat (16) begin
         at = INDEX_W'($urandom_range(0, NODE_COUNT - 1));
         if (board.reads_known(act, at)) return at;
      end
      return '0;
   endfunction

   // Mostly list operations on nodes still in the sentinel's chain, with some
   // loads, unused codes and operations on arbitrary nodes mixed in.
   function automatic list_op_type next_random_op(bit wide_loads);
      list_op_type op;
      int unsigned roll;
      int unsigned pos;
      bit          stray;
      roll          = $urandom_range(0, 99);
      op.value      = $urandom;
      op.link_next  = INDEX_W'($urandom);
      op.link_prev  = INDEX_W'($urandom);
      op.node_index = '0;
      if (roll < 4) begin
         op.action     = ACT_LOAD;
         op.node_index = wide_loads ? INDEX_W'($urandom_range(0, NODE_COUNT - 1))
                                    : INDEX_W'($urandom_range(0, board.free_slot - 1));
      end else if (roll < 7) begin
         op.action     = ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_CODE_MAX));
         op.node_index = INDEX_W'($urandom);
      end else begin
         if (roll < 27) op.action = ACT_INS_AFTER;
         else if (roll < 47) op.action = ACT_INS_BEFORE;
         else if (roll < 70) op.action = ACT_DELETE;
         else op.action = ACT_READ;
         stray = $urandom_range(0, 9) == 0;
         if (linked_nodes.size() == 0 &&
             (op.action == ACT_DELETE || op.action == ACT_READ)) stray = 1'b1;
         if (stray) begin
            op.node_index = pick_target(op.action);
         end else if (linked_nodes.size() == 0 || (op.action != ACT_DELETE &&
                      op.action != ACT_READ && $urandom_range(0, 4) == 0)) begin
            op.node_index = '0;
         end else begin
            pos           = $urandom_range(0, linked_nodes.size() - 1);
            op.node_index = linked_nodes[pos];
            if (op.action == ACT_DELETE) linked_nodes.delete(pos);
         end
         if (!board.reads_known(op.action, op.node_index))
            op.node_index = pick_target(op.action);
      end
      return op;
   endfunction

   // Offer one request word and wait until the block takes it.
   task automatic send_op(input list_op_type op);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= op.action;
      req_bus.node_index <= op.node_index;
      req_bus.value      <= op.value;
      req_bus.link_next  <= op.link_next;
      req_bus.link_prev  <= op.link_prev;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_request(op);
   endtask

   // Response side: random back-pressure, plus one long hold when asked for.
   initial begin : response_sink
      list_result_type got;
      int unsigned     wait_cycles;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         wait_cycles     = rsp_hold_cycles + (idle_on ? $urandom_range(0, 8) : 0);
         rsp_hold_cycles = 0;
         if (wait_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.result_value = rsp_bus.result_value;
         got.result_index = rsp_bus.result_index;
         got.result_next  = rsp_bus.result_next;
         got.result_prev  = rsp_bus.result_prev;
         got.pool_full    = rsp_bus.pool_full;
         board.check_result(got);
      end
   end

   initial begin : stimulus
      list_op_type op;
      int          counted;
      int          slot_before;
      bit          paused;
      bit          held;
      board              = new();
      idle_on            = 1'b1;
      rsp_hold_cycles    = 0;
      quiet_cycles       = 0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_LOAD;
      req_bus.node_index <= '0;
      req_bus.value      <= '0;
      req_bus.link_next  <= '0;
      req_bus.link_prev  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty list at the sentinel, then one insert on each side of it.
      send_op(op_of(ACT_LOAD, 0, 32'sh7FFF_FFFF, 0, 0));
      send_op(op_of(ACT_READ, 0, 0, 0, 0));
      send_op(op_of(ACT_INS_AFTER, 0, 32'sh8000_0000, 0, 0));
      send_op(op_of(ACT_INS_BEFORE, 0, -1, 0, 0));
      send_op(op_of(ACT_READ, 1, 0, 0, 0));
      send_op(op_of(ACT_READ, 2, 0, 0, 0));
      // An unlinked node whose links point at the free node and at the top entry;
      // deleting it writes the free node's next link, which an insert then names.
      send_op(op_of(ACT_LOAD, 3, 0, '1, 4));
      send_op(op_of(ACT_DELETE, 3, 0, 0, 0));
      send_op(op_of(ACT_INS_AFTER, 4, 32'sh5555_5555, 0, 0));
      send_op(op_of(ACT_READ, 4, 0, 0, 0));
      // Same again for insert-before, through the free node's previous link.
      send_op(op_of(ACT_LOAD, 4, 32'shAAAA_AAAA, 5, '1));
      send_op(op_of(ACT_DELETE, 4, 0, 0, 0));
      send_op(op_of(ACT_INS_BEFORE, 5, 0, 0, 0));
      send_op(op_of(ACT_READ, 5, 0, 0, 0));
      // Unlink the sentinel itself, then look at what it left behind.
      send_op(op_of(ACT_DELETE, 0, 0, 0, 0));
      send_op(op_of(ACT_READ, 1, 0, 0, 0));
      // Unused action codes must pass the index through untouched.
      send_op(op_of(ACT_FIRST_UNUSED, '1, -1, '1, '1));
      send_op(op_of(ACT_FIRST_UNUSED + 1, 10'h155, 32'sh1234_5678, 10'h2AA, 10'h155));
      send_op(op_of(ACT_CODE_MAX, 10'h2AA, 0, 0, 0));
      // Fresh empty list for the random part.
      send_op(op_of(ACT_LOAD, 0, 32'sh8000_0000, 0, 0));
      send_op(op_of(ACT_READ, 0, 0, 0, 0));

      counted = 0;
      paused  = 1'b0;
      held    = 1'b0;
      while (counted < RANDOM_OPS) begin
         idle_on = ((counted / 150) % 3) != 2;
         // Let the pipeline drain completely once before going on.
         if (counted >= PAUSE_AT && !paused) begin
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (board.outstanding() != 0);
         end
         // Stop taking responses for a while so the block fills and stalls.
         if (counted >= HOLD_AT && !held) begin
            held            = 1'b1;
            rsp_hold_cycles = HOLD_CYCLES;
         end
         op          = next_random_op(counted >= WIDE_LOAD_AT);
         slot_before = board.free_slot;
         send_op(op);
         if (op.action == ACT_INS_AFTER || op.action == ACT_INS_BEFORE) begin
            if (board.free_slot != slot_before) linked_nodes.push_back(INDEX_W'(slot_before));
         end
         if (op.action <= ACT_READ) counted++;
      end
      req_bus.valid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0 && board.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
